// ===== hdl/swg_pkg.sv =====
// Shared constants, register codes and fixed-point helpers for the waveform generator.
package swg_pkg;

  // Configuration register codes
  typedef enum logic [2:0] {
    REG_USE_OFFSET   = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_USE_SHAPE    = 3'd2,
    REG_SHAPE_MIX    = 3'd3,
    REG_USE_RANGE    = 3'd4,
    REG_RANGE_MIN    = 3'd5,
    REG_RANGE_MAX    = 3'd6
  } swg_reg_t;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic signed [15:0] BLEND_ONE = 16'sd16384;

  // Odd polynomial for a quarter sine, Q30
  localparam logic signed [31:0] SIN_C0 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C1 = -32'sd693598668;
  localparam logic signed [31:0] SIN_C2 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C3 = -32'sd5026995;
  localparam logic signed [31:0] SIN_C4 = 32'sd172272;

  // Digit-by-digit square root: 31 radicand bit pairs, 4 digits per stage
  localparam int SQ_PAIRS  = 31;
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = (SQ_PAIRS + SQ_STEPS - 1) / SQ_STEPS;

  // Q30 product, rounded half up
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = a * b;
    pr = pr + 64'sd536870912;
    return pr[61:30];
  endfunction

endpackage

// ===== hdl/swg_sine.sv =====
// Pipelined quarter-sine polynomial, at most one multiplier per stage.
module swg_sine
  import swg_pkg::*;
(
  input  logic        clk,
  input  logic [6:0]  en,
  input  logic [30:0] xs_in,
  output logic [30:0] mag
);

  logic signed [31:0] xs1, xs2, xs3, xs4, xs5;
  logic signed [31:0] t2_1, t2_2, t2_3, t2_4;
  logic signed [31:0] p3, p2, p1, p0, s6;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xs1  <= {1'b0, xs_in};
      t2_1 <= mul_q30({1'b0, xs_in}, {1'b0, xs_in});
    end
    if (en[1]) begin
      xs2  <= xs1;
      t2_2 <= t2_1;
      p3   <= SIN_C3 + mul_q30(SIN_C4, t2_1);
    end
    if (en[2]) begin
      xs3  <= xs2;
      t2_3 <= t2_2;
      p2   <= SIN_C2 + mul_q30(p3, t2_2);
    end
    if (en[3]) begin
      xs4  <= xs3;
      t2_4 <= t2_3;
      p1   <= SIN_C1 + mul_q30(p2, t2_3);
    end
    if (en[4]) begin
      xs5 <= xs4;
      p0  <= SIN_C0 + mul_q30(p1, t2_4);
    end
    if (en[5]) begin
      s6 <= mul_q30(p0, xs5);
    end
    if (en[6]) begin
      if (s6 < 0) begin
        mag <= '0;
      end else if (s6 > $signed({1'b0, ONE30})) begin
        mag <= ONE30;
      end else begin
        mag <= s6[30:0];
      end
    end
  end

endmodule

// ===== hdl/swg_sqrt.sv =====
// Pipelined digit-by-digit integer square root, floor result.
module swg_sqrt
  import swg_pkg::*;
(
  input  logic                 clk,
  input  logic [SQ_STAGES-1:0] en,
  input  logic [60:0]          rad_in,
  output logic [30:0]          root
);

  logic [32:0] rem_r  [SQ_STAGES];
  logic [30:0] root_r [SQ_STAGES];
  logic [61:0] rad_r  [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [32:0] rem_p, rem_c;
    logic [30:0] root_p, root_c;
    logic [61:0] rad_p, rad_c;
    logic [32:0] trial;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = {1'b0, rad_in};
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign rad_p  = rad_r[g-1];
    end

    always_comb begin
      rem_c  = rem_p;
      root_c = root_p;
      rad_c  = rad_p;
      trial = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        if (g * SQ_STEPS + k < SQ_PAIRS) begin
          rem_c = {rem_c[30:0], rad_c[61:60]};
          trial = {root_c[30:0], 2'b01};
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[29:0], 1'b1};
          end else begin
            root_c = {root_c[29:0], 1'b0};
          end
          rad_c = {rad_c[59:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_r[g]  <= rem_c;
        root_r[g] <= root_c;
        rad_r[g]  <= rad_c;
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];

endmodule

// ===== hdl/shaped_waveform_generator.sv =====
// Top level: phase prep, blend, range mapping and pipeline flow control.
// Shaped waveform generator.
// Input channel: phase with in_valid/in_stall; a transaction completes when
// in_valid is high and in_stall low. Output channel: wave_value with
// out_valid/out_stall, same rule. One result per input, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while the pipeline is empty.
// Pipeline stages from input transaction to out_valid: input register,
// squaring, eight square-root stages that also carry the sine polynomial,
// blend, rounding, range product, output register.
// Throughput: one item per cycle while out_stall is low. Each stage holds its item
// only while the stage ahead is full and not moving, so out_stall backs up
// stage by stage and empty slots are filled while the output waits.
// No item is dropped or repeated under stall.
// Reset (rst, synchronous) empties the pipeline and clears all config
// registers to zero.
module shaped_waveform_generator
  import swg_pkg::*;
#(
  parameter int PHASE_BITS     = 16,
  parameter int WAVE_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PHASE_BITS-1:0] phase,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    wave_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int NST = SQ_STAGES + 6;
  localparam int SQ_LAST = SQ_STAGES + 1;
  localparam int WB = WAVE_FRAC_BITS + 3;
  localparam int PW = WB + 17;
  localparam logic signed [49:0] RND44 = 50'sd1 <<< (43 - WAVE_FRAC_BITS);
  localparam logic signed [WB-1:0] WONE = WB'(1) <<< WAVE_FRAC_BITS;
  localparam logic signed [PW-1:0] RNDR = PW'(1) <<< WAVE_FRAC_BITS;

  // Configuration registers
  logic        use_offset, use_shape, use_range;
  logic [15:0] phase_offset;
  logic signed [15:0] shape_mix, range_min, range_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_offset   <= 1'b0;
      phase_offset <= '0;
      use_shape    <= 1'b0;
      shape_mix    <= '0;
      use_range    <= 1'b0;
      range_min    <= '0;
      range_max    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_USE_OFFSET:   use_offset   <= cfg_data[0];
        REG_PHASE_OFFSET: phase_offset <= cfg_data;
        REG_USE_SHAPE:    use_shape    <= cfg_data[0];
        REG_SHAPE_MIX:    shape_mix    <= cfg_data;
        REG_USE_RANGE:    use_range    <= cfg_data[0];
        REG_RANGE_MIN:    range_min    <= cfg_data;
        REG_RANGE_MAX:    range_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its content moves on
  logic [NST-1:0] v, mv;

  always_comb begin
    mv[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      mv[i] = !v[i] || mv[i+1];
    end
  end

  assign in_stall  = !mv[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (mv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (mv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: offset, quadrant, position in quadrant
  logic [PHASE_BITS-1:0] p_c;
  logic [29:0]           t_c;
  logic [1:0]            q0;
  logic [29:0]           t0;
  logic [30:0]           xs0, u0;

  always_comb begin
    p_c = phase;
    if (use_offset) begin
      p_c = phase + PHASE_BITS'(phase_offset);
    end
    t_c = {p_c[PHASE_BITS-3:0], {(32 - PHASE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      q0  <= p_c[PHASE_BITS-1 -: 2];
      t0  <= t_c;
      xs0 <= p_c[PHASE_BITS-2] ? (ONE30 - {1'b0, t_c}) : {1'b0, t_c};
      u0  <= p_c[PHASE_BITS-2] ? {1'b0, t_c} : (ONE30 - {1'b0, t_c});
    end
  end

  // Stage 1: circle radicand; q and t travel alongside the root stages
  logic [61:0] uu;
  logic [60:0] rad1;
  logic [1:0]  q_d [1:SQ_LAST];
  logic [29:0] t_d [1:SQ_LAST];

  assign uu = u0 * u0;

  always_ff @(posedge clk) begin
    if (mv[1]) begin
      rad1   <= 61'(62'h1000_0000_0000_0000 - uu);
      q_d[1] <= q0;
      t_d[1] <= t0;
    end
    for (int i = 2; i <= SQ_LAST; i++) begin
      if (mv[i]) begin
        q_d[i] <= q_d[i-1];
        t_d[i] <= t_d[i-1];
      end
    end
  end

  logic [30:0] sine_mag7;
  logic [30:0] sine_mag [8:SQ_LAST];
  logic [30:0] root_q;

  swg_sine u_sine (
    .clk   (clk),
    .en    (mv[7:1]),
    .xs_in (xs0),
    .mag   (sine_mag7)
  );

  swg_sqrt u_sqrt (
    .clk    (clk),
    .en     (mv[SQ_LAST:2]),
    .rad_in (rad1),
    .root   (root_q)
  );

  always_ff @(posedge clk) begin
    if (mv[8]) begin
      sine_mag[8] <= sine_mag7;
    end
    for (int i = 9; i <= SQ_LAST; i++) begin
      if (mv[i]) begin
        sine_mag[i] <= sine_mag[i-1];
      end
    end
  end

  // Blend stage
  logic               shape_on;
  logic signed [15:0] m_c, wgt_c;
  logic signed [31:0] sine_s, other_s;
  logic [1:0]         qb;
  logic [29:0]        tb;
  logic signed [47:0] pa, pb;
  logic signed [49:0] wave44;

  always_comb begin
    qb = q_d[SQ_LAST];
    tb = t_d[SQ_LAST];
    shape_on = use_shape && (shape_mix != 0) && (shape_mix >= -BLEND_ONE)
               && (shape_mix <= BLEND_ONE);
    sine_s = qb[1] ? -$signed({1'b0, sine_mag[SQ_LAST]}) : $signed({1'b0, sine_mag[SQ_LAST]});
    other_s = '0;
    m_c = '0;
    if (shape_on) begin
      if (shape_mix < 0) begin
        m_c = -shape_mix;
        unique case (qb)
          2'd0:    other_s = $signed({2'b00, tb});
          2'd1:    other_s = $signed({1'b0, ONE30}) - $signed({2'b00, tb});
          2'd2:    other_s = -$signed({2'b00, tb});
          default: other_s = $signed({2'b00, tb}) - $signed({1'b0, ONE30});
        endcase
      end else begin
        m_c = shape_mix;
        other_s = qb[1] ? -$signed({1'b0, root_q}) : $signed({1'b0, root_q});
      end
    end
    wgt_c = BLEND_ONE - m_c;
  end

  assign pa = sine_s * wgt_c;
  assign pb = other_s * m_c;

  always_ff @(posedge clk) begin
    if (mv[SQ_LAST+1]) begin
      wave44 <= 50'(pa) + 50'(pb);
    end
  end

  // Rounding stage
  logic signed [49:0]   wsum;
  logic signed [WB-1:0] w11, w12, base12;
  logic signed [PW-1:0] prod12;
  logic signed [16:0]   span;

  assign wsum = (wave44 + RND44) >>> (44 - WAVE_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (mv[SQ_LAST+2]) begin
      w11 <= wsum[WB-1:0];
    end
  end

  // Range product stage
  assign base12 = w11 + WONE;
  assign span   = 17'(range_max) - 17'(range_min);

  always_ff @(posedge clk) begin
    if (mv[SQ_LAST+3]) begin
      prod12 <= base12 * span;
      w12    <= w11;
    end
  end

  // Output stage: range offset, selection, saturation
  logic signed [PW-1:0] rng, fin;

  always_comb begin
    rng = PW'(range_min) + ((prod12 + RNDR) >>> (WAVE_FRAC_BITS + 1));
    fin = use_range ? rng : PW'(w12);
  end

  always_ff @(posedge clk) begin
    if (mv[NST-1]) begin
      if (fin > PW'(32767)) begin
        wave_value <= 16'sh7fff;
      end else if (fin < -PW'(32768)) begin
        wave_value <= -16'sh8000;
      end else begin
        wave_value <= fin[15:0];
      end
    end
  end

endmodule
